// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
		else $error("property violated");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// ===== src/gms_pkg.sv =====
// types and constants of the two-axis galvo move stepper
`timescale 1ns / 1ps

package gms_pkg;

	typedef logic [1:0] op_t;

	localparam op_t OP_TICK = 2'd0;
	localparam op_t OP_LOAD = 2'd1;
	localparam op_t OP_SET  = 2'd2;

	localparam int STEP_W     = 32;
	localparam int SPEED_W    = 32;
	localparam int PERIOD_W   = 16;
	localparam int FRAC_SHIFT = 10;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WRITE,
		PH_CONFIRM
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQSUM,
		ST_ROOT,
		ST_DIV_SPEED,
		ST_DIV_PERIOD,
		ST_DIV_X,
		ST_DIV_Y,
		ST_COMMIT
	} seq_state_t;

endpackage

// ===== src/gms_sqsum.sv =====
// bit-serial sum of squares dx*dx + dy*dy
`timescale 1ns / 1ps

module gms_sqsum #(
	parameter int DAC_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DAC_BITS-1:0]   dx,
	input  logic [DAC_BITS-1:0]   dy,
	output logic [2*DAC_BITS:0]   sum,
	output logic                  done
);

	localparam int MW = 2 * DAC_BITS;
	localparam int SW = 2 * DAC_BITS + 1;
	localparam int CW = $clog2(DAC_BITS);
	localparam logic [CW-1:0] LAST = CW'(DAC_BITS - 1);

	logic [MW-1:0]       mcand_q;
	logic [DAC_BITS-1:0] mult_q;
	logic [DAC_BITS-1:0] dy_hold_q;
	logic [SW-1:0]       acc_q;
	logic [CW-1:0]       cnt_q;
	logic                second_q;
	logic                busy_q;
	logic                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			second_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				second_q <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					cnt_q <= '0;
					if (!second_q) begin
						second_q <= 1'b1;
					end else begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q   <= MW'(dx);
			mult_q    <= dx;
			dy_hold_q <= dy;
			acc_q     <= '0;
		end else if (busy_q) begin
			if (mult_q[0]) begin
				acc_q <= acc_q + SW'(mcand_q);
			end
			if (cnt_q == LAST && !second_q) begin
				mcand_q <= MW'(dy_hold_q);
				mult_q  <= dy_hold_q;
			end else begin
				mcand_q <= mcand_q << 1;
				mult_q  <= mult_q >> 1;
			end
		end
	end

	assign sum  = acc_q;
	assign done = done_q;

endmodule

// ===== src/gms_sqrt.sv =====
// digit-serial integer square root, two radicand bits per cycle
`timescale 1ns / 1ps

module gms_sqrt #(
	parameter int DAC_BITS = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2*DAC_BITS:0]  radicand,
	output logic [DAC_BITS:0]    root,
	output logic                 done
);

	localparam int RW  = DAC_BITS + 1;
	localparam int VW  = 2 * RW;
	localparam int RMW = RW + 3;
	localparam int CW  = $clog2(RW);
	localparam logic [CW-1:0] LAST = CW'(RW - 1);

	logic [VW-1:0]  v_q;
	logic [RW:0]    rem_q;
	logic [RW-1:0]  root_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [RMW-1:0] rem_sh;
	logic [RMW-1:0] trial;
	logic [RMW-1:0] diff;
	logic           fits;

	assign rem_sh = {rem_q, v_q[VW-1 -: 2]};
	assign trial  = RMW'({root_q, 2'b01});
	assign diff   = rem_sh - trial;
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= VW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= v_q << 2;
			rem_q  <= fits ? diff[RW:0] : rem_sh[RW:0];
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ===== src/gms_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module gms_div #(
	parameter int NW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NW-1:0]              numer,
	input  logic [gms_pkg::STEP_W-1:0] denom,
	output logic [NW-1:0]              quot,
	output logic                       done
);

	import gms_pkg::*;

	localparam int CW = $clog2(NW);
	localparam logic [CW-1:0] LAST = CW'(NW - 1);

	logic [NW-1:0]     q_q;
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] den_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [STEP_W:0]   trial;
	logic [STEP_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, q_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			q_q   <= {q_q[NW-2:0], fits};
			rem_q <= fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
		end
	end

	assign quot = q_q;
	assign done = done_q;

endmodule

// ===== src/gms_axis.sv =====
// one axis update: step toward target and clamp on arrival
`timescale 1ns / 1ps

module gms_axis #(
	parameter int DAC_BITS = 18
) (
	input  logic [DAC_BITS-1:0]        pos,
	input  logic [DAC_BITS-1:0]        tgt,
	input  logic [gms_pkg::STEP_W-1:0] step,
	output logic [DAC_BITS-1:0]        pos_nxt,
	output logic                       at_tgt
);

	import gms_pkg::*;

	logic                below;
	logic [DAC_BITS-1:0] distance;
	logic                reach;

	assign below    = pos < tgt;
	assign distance = below ? (tgt - pos) : (pos - tgt);
	assign reach    = step >= STEP_W'(distance);
	assign at_tgt   = pos == tgt;

	always_comb begin
		if (at_tgt) begin
			pos_nxt = pos;
		end else if (reach) begin
			pos_nxt = tgt;
		end else if (below) begin
			pos_nxt = pos + step[DAC_BITS-1:0];
		end else begin
			pos_nxt = pos - step[DAC_BITS-1:0];
		end
	end

endmodule

// ===== src/two_axis_galvo_move_stepper_unit.sv =====
// top level of the two-axis galvo move stepper
//
// Input channel (in_valid/in_ready) carries one operation per transaction:
// tick, load move or set position. Output channel (out_valid/out_ready)
// returns exactly one result per input transaction, in order.
// update_period is written through cfg_write_en/cfg_write_data; the user
// must write it only while idle, the block itself does not enforce this.
// Tick, set and unused operations pass from acceptance through the commit
// state into the output register; the next transaction is taken only once
// the sequencer is back in idle. Load: sum of squares, then root, then four
// divisions on the one shared serial divider of NW quotient bits (NW = 32,
// or DAC_BITS+10 when wider). A zero speed skips the divisions.
// The serial units set the load time; ticks are bound by the two-state
// accept/commit sequence.
// Reset clears positions, targets and steps to zero, the phase to idle and
// update_period to 10.
// When the receiver stalls, the finished result waits in the output register;
// the next transaction is still accepted and computed, and waits at its
// commit until the output register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_axis_galvo_move_stepper_unit #(
	parameter int DAC_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [gms_pkg::PERIOD_W-1:0] cfg_write_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  gms_pkg::op_t                 operation,
	input  logic [DAC_BITS-1:0]          from_x,
	input  logic [DAC_BITS-1:0]          from_y,
	input  logic [DAC_BITS-1:0]          to_x,
	input  logic [DAC_BITS-1:0]          to_y,
	input  logic [gms_pkg::SPEED_W-1:0]  speed,
	input  logic                         enable_x,
	input  logic                         enable_y,
	input  logic [DAC_BITS-1:0]          set_x,
	input  logic [DAC_BITS-1:0]          set_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [DAC_BITS-1:0]          x_out,
	output logic [DAC_BITS-1:0]          y_out,
	output logic                         dac_write,
	output logic                         settled,
	output logic                         move_complete,
	output logic                         busy_res
);

	import gms_pkg::*;

	localparam int RW = DAC_BITS + 1;
	localparam int NW = (DAC_BITS + FRAC_SHIFT > STEP_W) ? DAC_BITS + FRAC_SHIFT : STEP_W;

	// sequencer
	seq_state_t seq_q;
	seq_state_t seq_d;

	// accepted transaction
	op_t                 op_q;
	logic [DAC_BITS-1:0] dx_q;
	logic [DAC_BITS-1:0] dy_q;
	logic [DAC_BITS-1:0] to_x_q;
	logic [DAC_BITS-1:0] to_y_q;
	logic [SPEED_W-1:0]  speed_q;
	logic                en_x_q;
	logic                en_y_q;
	logic [DAC_BITS-1:0] set_x_q;
	logic [DAC_BITS-1:0] set_y_q;

	// block state
	logic [PERIOD_W-1:0] period_q;
	logic [DAC_BITS-1:0] position_x_q;
	logic [DAC_BITS-1:0] position_y_q;
	logic [DAC_BITS-1:0] target_x_q;
	logic [DAC_BITS-1:0] target_y_q;
	logic [STEP_W-1:0]   step_x_q;
	logic [STEP_W-1:0]   step_y_q;
	logic [STEP_W-1:0]   incr_q;
	phase_t              phase_q;
	logic                finished_q;

	// output register
	logic                out_valid_q;
	logic [DAC_BITS-1:0] x_out_q;
	logic [DAC_BITS-1:0] y_out_q;
	logic                dac_write_q;
	logic                settled_q;
	logic                complete_q;
	logic                busy_q;

	// datapath
	logic [DAC_BITS-1:0]   dx_in;
	logic [DAC_BITS-1:0]   dy_in;
	logic [2*DAC_BITS:0]   sq_sum;
	logic                  sq_done;
	logic [RW-1:0]         root;
	logic                  root_done;
	logic [RW+FRAC_SHIFT-1:0] dist_full;
	logic [STEP_W-1:0]     distance;
	logic [NW-1:0]         quot;
	logic [NW-1:0]         quot_sh;
	logic                  div_done;
	logic [STEP_W-1:0]     dur;
	logic [STEP_W-1:0]     incr_c;
	logic [STEP_W-1:0]     per_c;
	logic [STEP_W-1:0]     quot_lo;

	// control
	logic                  accept;
	logic                  out_free;
	logic                  sq_start;
	logic                  root_start;
	logic                  div_start;
	logic [NW-1:0]         div_num;
	logic [STEP_W-1:0]     div_den;
	logic                  commit;

	// commit values
	logic [DAC_BITS-1:0] nxt_x;
	logic [DAC_BITS-1:0] nxt_y;
	logic                at_x;
	logic                at_y;
	logic [DAC_BITS-1:0] pos_x_d;
	logic [DAC_BITS-1:0] pos_y_d;
	logic [DAC_BITS-1:0] tgt_x_d;
	logic [DAC_BITS-1:0] tgt_y_d;
	phase_t              phase_d;
	logic                fin_d;
	logic                wrote_d;
	logic                settled_d;

	assign dx_in   = (to_x > from_x) ? (to_x - from_x) : (from_x - to_x);
	assign dy_in   = (to_y > from_y) ? (to_y - from_y) : (from_y - to_y);
	assign dist_full = {root, {FRAC_SHIFT{1'b0}}};
	assign distance = STEP_W'(dist_full);
	assign quot_sh = quot << FRAC_SHIFT;
	assign dur     = quot_sh[STEP_W-1:0];
	assign quot_lo = quot[STEP_W-1:0];
	assign incr_c  = (quot_lo == '0) ? STEP_W'(1) : quot_lo;
	assign per_c   = (period_q == '0) ? STEP_W'(1) : STEP_W'(period_q);
	assign out_free = !out_valid_q || out_ready;

	gms_sqsum #(
		.DAC_BITS(DAC_BITS)
	) u_sqsum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.dx     (dx_in),
		.dy     (dy_in),
		.sum    (sq_sum),
		.done   (sq_done)
	);

	gms_sqrt #(
		.DAC_BITS(DAC_BITS)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_sum),
		.root     (root),
		.done     (root_done)
	);

	gms_div #(
		.NW(NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (div_den),
		.quot   (quot),
		.done   (div_done)
	);

	gms_axis #(
		.DAC_BITS(DAC_BITS)
	) u_axis_x (
		.pos     (position_x_q),
		.tgt     (target_x_q),
		.step    (step_x_q),
		.pos_nxt (nxt_x),
		.at_tgt  (at_x)
	);

	gms_axis #(
		.DAC_BITS(DAC_BITS)
	) u_axis_y (
		.pos     (position_y_q),
		.tgt     (target_y_q),
		.step    (step_y_q),
		.pos_nxt (nxt_y),
		.at_tgt  (at_y)
	);

	// next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			ST_IDLE: begin
				if (in_valid) begin
					seq_d = (operation == OP_LOAD) ? ST_SQSUM : ST_COMMIT;
				end
			end
			ST_SQSUM: begin
				if (sq_done) begin
					seq_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_done) begin
					seq_d = (speed_q == '0) ? ST_COMMIT : ST_DIV_SPEED;
				end
			end
			ST_DIV_SPEED: begin
				if (div_done) begin
					seq_d = ST_DIV_PERIOD;
				end
			end
			ST_DIV_PERIOD: begin
				if (div_done) begin
					seq_d = ST_DIV_X;
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					seq_d = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					seq_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					seq_d = ST_IDLE;
				end
			end
			default: seq_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		sq_start   = 1'b0;
		root_start = 1'b0;
		div_start  = 1'b0;
		div_num    = NW'(distance);
		div_den    = speed_q;
		commit     = 1'b0;
		case (seq_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				sq_start = in_valid && (operation == OP_LOAD);
			end
			ST_SQSUM: begin
				root_start = sq_done;
			end
			ST_ROOT: begin
				div_start = root_done && (speed_q != '0);
			end
			ST_DIV_SPEED: begin
				div_start = div_done;
				div_num   = NW'(dur);
				div_den   = per_c;
			end
			ST_DIV_PERIOD: begin
				div_start = div_done;
				div_num   = NW'({dx_q, {FRAC_SHIFT{1'b0}}});
				div_den   = incr_c;
			end
			ST_DIV_X: begin
				div_start = div_done;
				div_num   = NW'({dy_q, {FRAC_SHIFT{1'b0}}});
				div_den   = incr_q;
			end
			ST_DIV_Y: begin
			end
			ST_COMMIT: begin
				commit = out_free;
			end
			default: begin
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// state after the current transaction
	always_comb begin
		pos_x_d   = position_x_q;
		pos_y_d   = position_y_q;
		tgt_x_d   = target_x_q;
		tgt_y_d   = target_y_q;
		phase_d   = phase_q;
		fin_d     = finished_q;
		wrote_d   = 1'b0;
		settled_d = 1'b0;
		case (op_q)
			OP_LOAD: begin
				tgt_x_d = to_x_q;
				tgt_y_d = to_y_q;
				phase_d = PH_WRITE;
				fin_d   = 1'b0;
			end
			OP_SET: begin
				pos_x_d = set_x_q;
				pos_y_d = set_y_q;
			end
			OP_TICK: begin
				case (phase_q)
					PH_WRITE: begin
						pos_x_d   = nxt_x;
						pos_y_d   = nxt_y;
						wrote_d   = 1'b1;
						settled_d = at_x && at_y;
						if (at_x && at_y) begin
							phase_d = PH_CONFIRM;
						end
					end
					PH_CONFIRM: begin
						if (at_x && at_y) begin
							fin_d   = 1'b1;
							phase_d = PH_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= ST_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			dx_q    <= dx_in;
			dy_q    <= dy_in;
			to_x_q  <= to_x;
			to_y_q  <= to_y;
			speed_q <= speed;
			en_x_q  <= enable_x;
			en_y_q  <= enable_y;
			set_x_q <= set_x;
			set_y_q <= set_y;
		end
		if (seq_q == ST_DIV_PERIOD && div_done) begin
			incr_q <= incr_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_write_en) begin
			period_q <= cfg_write_data;
		end
	end

	// step sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q <= '0;
			step_y_q <= '0;
		end else begin
			if (seq_q == ST_ROOT && root_done && speed_q == '0) begin
				step_x_q <= '0;
				step_y_q <= '0;
			end
			if (seq_q == ST_DIV_X && div_done) begin
				step_x_q <= (en_x_q && dx_q != '0) ? quot_lo : '0;
			end
			if (seq_q == ST_DIV_Y && div_done) begin
				step_y_q <= (en_y_q && dy_q != '0) ? quot_lo : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_x_q <= '0;
			position_y_q <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			phase_q      <= PH_IDLE;
			finished_q   <= 1'b0;
		end else if (commit) begin
			position_x_q <= pos_x_d;
			position_y_q <= pos_y_d;
			target_x_q   <= tgt_x_d;
			target_y_q   <= tgt_y_d;
			phase_q      <= phase_d;
			finished_q   <= fin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			x_out_q     <= pos_x_d;
			y_out_q     <= pos_y_d;
			dac_write_q <= wrote_d;
			settled_q   <= settled_d;
			complete_q  <= fin_d;
			busy_q      <= (phase_d == PH_WRITE) || (phase_d == PH_CONFIRM);
		end
	end

	assign out_valid     = out_valid_q;
	assign x_out         = x_out_q;
	assign y_out         = y_out_q;
	assign dac_write     = dac_write_q;
	assign settled       = settled_q;
	assign move_complete = complete_q;
	assign busy_res      = busy_q;

	`ASSERT_IMPLIES(a_fin_not_writing, clk, arst_n, finished_q, phase_q != PH_WRITE)
	`ASSERT_IMPLIES(a_fin_on_target, clk, arst_n, $rose(finished_q), at_x && at_y)
	`ASSERT_IMPLIES(a_result_from_commit, clk, arst_n, $rose(out_valid_q), $past(seq_q == ST_COMMIT))
	`ASSERT_ALWAYS(a_single_unit_start, clk, arst_n, $onehot0({sq_start, root_start, div_start}))

endmodule

// ===== test/tb_two_axis_galvo_move_stepper_unit.sv =====
// self-checking random testbench of the two-axis galvo move stepper
`timescale 1ns / 1ps

module tb_two_axis_galvo_move_stepper_unit;
	import gms_pkg::*;

	localparam int DAC_BITS = 18;
	localparam int CYCLE_LIMIT = 1000000;
	localparam op_t OP_NONE = 2'd3;
	localparam logic [DAC_BITS-1:0] DAC_MAX = '1;

	typedef struct {
		op_t                 op;
		logic [DAC_BITS-1:0] fx, fy, tx, ty;
		logic [SPEED_W-1:0]  spd;
		logic                ex, ey;
		logic [DAC_BITS-1:0] sx, sy;
	} move_item_t;

	typedef struct {
		logic [DAC_BITS-1:0] x, y;
		logic                wr, st, done, busy;
	} dac_result_t;

	class galvo_scoreboard;
		logic [PERIOD_W-1:0] period;
		logic [DAC_BITS-1:0] pos_x, pos_y, tgt_x, tgt_y;
		logic [STEP_W-1:0]   step_x, step_y;
		phase_t              phase;
		bit                  finished;
		dac_result_t         pending_dac[$];
		int                  errors, loads, writes, completions;

		function new();
			period = PERIOD_RESET;
			pos_x = '0;
			pos_y = '0;
			tgt_x = '0;
			tgt_y = '0;
			step_x = '0;
			step_y = '0;
			phase = PH_IDLE;
			finished = 1'b0;
			errors = 0;
			loads = 0;
			writes = 0;
			completions = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			r = $rtoi($sqrt(real'(v)));
			while (r * r > v)
				r--;
			while ((r + 1) * (r + 1) <= v)
				r++;
			return r;
		endfunction

		function logic [STEP_W-1:0] step_size(longint unsigned delta, logic [31:0] incr, bit en,
				logic [SPEED_W-1:0] spd);
			if (!en || delta == 0 || spd == 0)
				return '0;
			return STEP_W'((delta << FRAC_SHIFT) / incr);
		endfunction

		// clamps on the target, also where the step would wrap the position
		function logic [DAC_BITS-1:0] move_axis(logic [DAC_BITS-1:0] p, logic [DAC_BITS-1:0] t,
				logic [STEP_W-1:0] s);
			if (p < t)
				return (s >= t - p) ? t : p + s[DAC_BITS-1:0];
			if (p > t)
				return (s >= p - t) ? t : p - s[DAC_BITS-1:0];
			return p;
		endfunction

		function void predict_item(move_item_t it);
			dac_result_t     r;
			longint unsigned dx, dy, root;
			logic [31:0]     distance, dur, incr;
			logic [PERIOD_W-1:0] per;
			bit              at_x, at_y;
			r.wr = 1'b0;
			r.st = 1'b0;
			case (it.op)
				OP_LOAD: begin
					dx = (it.tx > it.fx) ? it.tx - it.fx : it.fx - it.tx;
					dy = (it.ty > it.fy) ? it.ty - it.fy : it.fy - it.ty;
					root = int_sqrt(dx * dx + dy * dy);
					distance = 32'(root << FRAC_SHIFT);
					dur = '0;
					if (it.spd != 0)
						dur = (distance / it.spd) << FRAC_SHIFT;
					per = (period == 0) ? 16'd1 : period;
					incr = dur / per;
					if (incr == 0)
						incr = 1;
					step_x = step_size(dx, incr, it.ex, it.spd);
					step_y = step_size(dy, incr, it.ey, it.spd);
					tgt_x = it.tx;
					tgt_y = it.ty;
					phase = PH_WRITE;
					finished = 1'b0;
					loads++;
				end
				OP_SET: begin
					pos_x = it.sx;
					pos_y = it.sy;
				end
				OP_TICK: begin
					if (phase == PH_WRITE) begin
						at_x = (pos_x == tgt_x);
						at_y = (pos_y == tgt_y);
						pos_x = move_axis(pos_x, tgt_x, step_x);
						pos_y = move_axis(pos_y, tgt_y, step_y);
						r.wr = 1'b1;
						r.st = at_x && at_y;
						writes++;
						if (r.st)
							phase = PH_CONFIRM;
					end else if (phase == PH_CONFIRM && pos_x == tgt_x && pos_y == tgt_y) begin
						finished = 1'b1;
						phase = PH_IDLE;
						completions++;
					end
				end
				default: ;
			endcase
			r.x = pos_x;
			r.y = pos_y;
			r.done = finished;
			r.busy = (phase != PH_IDLE);
			pending_dac.push_back(r);
		endfunction

		function void compare(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (want_v !== got_v) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
			end
		endfunction

		function void check_dac_result(dac_result_t got);
			dac_result_t want;
			if (pending_dac.size() == 0) begin
				errors++;
				$display("%0t: unexpected result x=%0h y=%0h", $time, got.x, got.y);
				return;
			end
			want = pending_dac.pop_front();
			compare("x_out", 32'(want.x), 32'(got.x));
			compare("y_out", 32'(want.y), 32'(got.y));
			compare("dac_write", 32'(want.wr), 32'(got.wr));
			compare("settled", 32'(want.st), 32'(got.st));
			compare("move_complete", 32'(want.done), 32'(got.done));
			compare("busy_res", 32'(want.busy), 32'(got.busy));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [PERIOD_W-1:0]   cfg_write_data;
	logic                  in_valid;
	logic                  in_ready;
	op_t                   operation;
	logic [DAC_BITS-1:0]   from_x, from_y, to_x, to_y;
	logic [SPEED_W-1:0]    speed;
	logic                  enable_x, enable_y;
	logic [DAC_BITS-1:0]   set_x, set_y;
	logic                  out_valid;
	logic                  out_ready;
	logic [DAC_BITS-1:0]   x_out, y_out;
	logic                  dac_write, settled, move_complete, busy_res;

	galvo_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int stall_left = 0;
	int items_sent = 0;
	int periods_used = 0;
	int cycles = 0;

	two_axis_galvo_move_stepper_unit #(
		.DAC_BITS(DAC_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.from_x(from_x),
		.from_y(from_y),
		.to_x(to_x),
		.to_y(to_y),
		.speed(speed),
		.enable_x(enable_x),
		.enable_y(enable_y),
		.set_x(set_x),
		.set_y(set_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.x_out(x_out),
		.y_out(y_out),
		.dac_write(dac_write),
		.settled(settled),
		.move_complete(move_complete),
		.busy_res(busy_res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached, %0d results outstanding", $time,
				sb.pending_dac.size());
			$display("tb_two_axis_galvo_move_stepper_unit: errors");
			$finish;
		end
	end

	// result side: check each transaction, stall in bursts
	initial begin
		dac_result_t got;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.x = x_out;
				got.y = y_out;
				got.wr = dac_write;
				got.st = settled;
				got.done = move_complete;
				got.busy = busy_res;
				sb.check_dac_result(got);
			end
			if (stall_left != 0)
				stall_left--;
			else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 18);
			out_ready <= (stall_left == 0);
		end
	end

	function automatic move_item_t random_item(op_t op);
		move_item_t it;
		it.op = op;
		it.fx = DAC_BITS'($urandom);
		it.fy = DAC_BITS'($urandom);
		it.tx = DAC_BITS'($urandom);
		it.ty = DAC_BITS'($urandom);
		it.spd = $urandom;
		it.ex = 1'($urandom);
		it.ey = 1'($urandom);
		it.sx = DAC_BITS'($urandom);
		it.sy = DAC_BITS'($urandom);
		return it;
	endfunction

	function automatic move_item_t load_item(logic [DAC_BITS-1:0] fx, logic [DAC_BITS-1:0] fy,
			logic [DAC_BITS-1:0] tx, logic [DAC_BITS-1:0] ty, logic [SPEED_W-1:0] spd,
			logic ex, logic ey);
		move_item_t it;
		it = random_item(OP_LOAD);
		it.fx = fx;
		it.fy = fy;
		it.tx = tx;
		it.ty = ty;
		it.spd = spd;
		it.ex = ex;
		it.ey = ey;
		return it;
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 8;
			default: return 35;
		endcase
	endfunction

	task automatic send_item(move_item_t it);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		from_x <= it.fx;
		from_y <= it.fy;
		to_x <= it.tx;
		to_y <= it.ty;
		speed <= it.spd;
		enable_x <= it.ex;
		enable_y <= it.ey;
		set_x <= it.sx;
		set_y <= it.sy;
		do
			@(posedge clk);
		while (!in_ready);
		sb.predict_item(it);
		if (it.op != OP_NONE)
			items_sent++;
	endtask

	// ticks until the move is confirmed or cap is reached, with the odd position reload mid-move
	task automatic run_ticks(int cap);
		move_item_t it;
		for (int i = 0; i < cap && sb.phase != PH_IDLE; i++) begin
			it = random_item(OP_TICK);
			if ($urandom_range(0, 99) < 3)
				it.op = OP_SET;
			send_item(it);
		end
	endtask

	task automatic run_move();
		move_item_t      it;
		longint unsigned dx, dy, root, per;
		int              n;
		if ($urandom_range(0, 99) < 25)
			send_item(random_item(OP_SET));
		it = random_item(OP_LOAD);
		if ($urandom_range(0, 99) < 90) begin
			it.fx = sb.pos_x;
			it.fy = sb.pos_y;
		end
		if ($urandom_range(0, 99) < 40) begin
			it.tx = it.fx ^ DAC_BITS'($urandom_range(0, 255));
			it.ty = it.fy ^ DAC_BITS'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 99) < 80) begin
			it.ex = 1'b1;
			it.ey = 1'b1;
		end
		dx = (it.tx > it.fx) ? it.tx - it.fx : it.fx - it.tx;
		dy = (it.ty > it.fy) ? it.ty - it.fy : it.fy - it.ty;
		root = sb.int_sqrt(dx * dx + dy * dy);
		per = (sb.period == 0) ? 1 : sb.period;
		n = $urandom_range(1, 24);
		case ($urandom_range(0, 19))
			0: it.spd = '0;
			1: it.spd = '1;
			2: ;
			default: begin
				// aim at roughly n updates for the move
				it.spd = SPEED_W'((root << FRAC_SHIFT) / (n * per));
				if (it.spd == 0)
					it.spd = 1;
			end
		endcase
		send_item(it);
		run_ticks(40);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_dac.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_period(logic [PERIOD_W-1:0] v);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.period = v;
		periods_used++;
	endtask

	initial begin
		move_item_t          it;
		logic [PERIOD_W-1:0] per_val;
		int                  budget;
		sb = new();
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		in_valid = 1'b0;
		operation = OP_TICK;
		from_x = '0;
		from_y = '0;
		to_x = '0;
		to_y = '0;
		speed = '0;
		enable_x = 1'b0;
		enable_y = 1'b0;
		set_x = '0;
		set_y = '0;
		idle_pct = 20;
		stall_pct = 20;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset period
		send_item(random_item(OP_TICK));
		send_item(random_item(OP_NONE));
		it = random_item(OP_SET);
		it.sx = DAC_MAX;
		it.sy = DAC_MAX;
		send_item(it);
		it = random_item(OP_SET);
		it.sx = '0;
		it.sy = '0;
		send_item(it);
		// zero speed: no steps, axis stays off target
		send_item(load_item('0, '0, DAC_MAX, DAC_MAX, '0, 1'b1, 1'b1));
		repeat (2) send_item(random_item(OP_TICK));
		// one oversized step that would wrap the position
		send_item(load_item('0, '0, DAC_MAX, DAC_MAX, '1, 1'b1, 1'b1));
		run_ticks(3);
		// duration wraps at unit speed
		send_item(load_item(DAC_MAX, DAC_MAX, '0, '0, 32'd1, 1'b1, 1'b1));
		run_ticks(4);
		// x axis disabled
		send_item(load_item(sb.pos_x, sb.pos_y, DAC_MAX, 18'd5, 32'd900, 1'b0, 1'b1));
		run_ticks(2);
		// reach confirm, then move both axes off target before the confirm tick
		send_item(load_item(sb.pos_x, sb.pos_y, 18'd100, 18'd100, '1, 1'b1, 1'b1));
		repeat (2) send_item(random_item(OP_TICK));
		it = random_item(OP_SET);
		it.sx = 18'd7;
		it.sy = 18'd7;
		send_item(it);
		send_item(random_item(OP_TICK));

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: per_val = 16'd1;
				1: per_val = 16'hFFFF;
				2: per_val = 16'd0;
				3: per_val = $urandom_range(2, 2000);
				4: per_val = $urandom_range(2, 65534);
				default: per_val = PERIOD_RESET;
			endcase
			drain();
			write_period(per_val);
			budget = items_sent + 185;
			while (items_sent < budget) begin
				if (ph == 5) begin
					idle_pct = 0;
					stall_pct = 0;
				end else begin
					idle_pct = pick_idle();
					stall_pct = pick_idle();
				end
				if ($urandom_range(0, 99) < 15)
					repeat ($urandom_range(1, 4)) send_item(random_item(op_t'($urandom_range(0, 3))));
				else
					run_move();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("run covered %0d transactions over %0d period settings", items_sent, periods_used + 1);
		$display("%0d loads, %0d dac writes, %0d confirmed moves", sb.loads, sb.writes,
			sb.completions);
		if (sb.errors == 0 && sb.pending_dac.size() == 0)
			$display("tb_two_axis_galvo_move_stepper_unit: clean");
		else
			$display("tb_two_axis_galvo_move_stepper_unit: errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/gms_pkg.sv
src/gms_sqsum.sv
src/gms_sqrt.sv
src/gms_div.sv
src/gms_axis.sv
src/two_axis_galvo_move_stepper_unit.sv
test/tb_two_axis_galvo_move_stepper_unit.sv
